[hw/rtl/hbrp_pkg.sv]
// Shared types and constants for the byte-range header parser.
// Used by the front, queue, back and top-level modules; no dependencies.
package hbrp_pkg;

    localparam int VAL_W = 62;
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    typedef struct packed {
        logic [7:0] byte_req;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic              is_status;
        logic [1:0]        kind;
        logic [VAL_W-1:0]  start_pos;
        logic [VAL_W-1:0]  end_pos;
        logic signed [63:0] span;
        logic              saturated;
        logic [1:0]        status;
        logic [4:0]        range_count;
        logic              done_res;
    } out_item_t;

    localparam logic [1:0] KIND_CLOSED = 2'd0;
    localparam logic [1:0] KIND_OPEN   = 2'd1;
    localparam logic [1:0] KIND_SUFFIX = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADUNIT = 2'd1;
    localparam logic [1:0] ST_NOEQ    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // command from front to back
    typedef struct packed {
        logic             has_range;
        logic [1:0]       kind;
        logic [VAL_W-1:0] first_value;
        logic [VAL_W-1:0] second_value;
        logic             sat;
        logic             has_status;
        logic [1:0]       status;
        logic [4:0]       count;
    } cmd_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [7:0] unit_char(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0: r = 8'h62;
            3'd1: r = 8'h79;
            3'd2: r = 8'h74;
            3'd3: r = 8'h65;
            default: r = 8'h73;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/http_byte_range_parser_core.sv]
// Top level of the HTTP Range header parser.
// Depends on hbrp_pkg, hbrp_front, hbrp_fifo and hbrp_back.
//
// Usage: bytes of the header value enter on a queue-style port (push/full),
// one beat per byte, with last set on the final byte. Results leave on a
// queue-style port (empty/pop): a range beat for each accepted token, then a
// status beat with done_res set at the end of every header.
// A result passes through the front's command register, the command queue and the back part's result register.
// Throughput: one byte per cycle while full is low; full rises only when the command queue
// cannot hold two more commands, which happens when pop is held low.
// A header end that also closes a token costs two output beats; the back
// part drains them at one beat per cycle while pop is high.
// Reset clears parser state and empties both queues; the byte stream must
// restart at a header's beginning. A stalled receiver holds the current
// beat on the result ports and backs pressure up into full.
module http_byte_range_parser_core #(
    parameter int MAX_RANGES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  hbrp_pkg::in_item_t  in_item,
    output logic                empty,
    input  logic                pop,
    output hbrp_pkg::out_item_t out_item
);
    localparam int QDEPTH = 4;
    logic cmd_valid, cmd_take, q_ne, q_space;
    hbrp_pkg::cmd_t cmd_w, cmd_r;
    logic inflight_reg;

    // one command may be in the front's output register; keep room for it
    assign full = !q_space || (inflight_reg && !q_space);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) inflight_reg <= 1'b0;
        else inflight_reg <= push && !full;
    end

    hbrp_front #(.MAX_RANGES(MAX_RANGES)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(push && !full), .in_item(in_item),
        .cmd_valid(cmd_valid), .cmd(cmd_w)
    );

    hbrp_fifo #(.DEPTH(QDEPTH)) u_fifo (
        .clk(clk), .rst_n(rst_n), .wr(cmd_valid), .wdata(cmd_w),
        .rd(cmd_take), .rdata(cmd_r), .nonempty(q_ne), .space2(q_space)
    );

    hbrp_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_avail(q_ne), .cmd(cmd_r), .cmd_take(cmd_take),
        .empty(empty), .pop(pop), .res(out_item)
    );
endmodule

[hw/rtl/hbrp_front.sv]
// Front part: prefix match, tokenising and decimal accumulation.
// Depends on hbrp_pkg; emits one command for each byte that ends a header or a valid token.
module hbrp_front #(
    parameter int MAX_RANGES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  hbrp_pkg::in_item_t in_item,
    output logic              cmd_valid,
    output hbrp_pkg::cmd_t    cmd
);
    localparam int CW = $clog2(MAX_RANGES + 1);

    typedef enum logic [2:0] {
        PH_PREFIX, PH_BEFORE_EQ, PH_AFTER_EQ, PH_TOKENS, PH_SKIP, PH_FAILED
    } phase_t;
    typedef enum logic [2:0] {
        TK_START, TK_FIRST, TK_DASH, TK_SECOND, TK_SUF_DASH, TK_SUFFIX, TK_OPEN, TK_BAD
    } tok_t;

    phase_t phase_reg, phase_next;
    tok_t   tok_reg, tok_next;
    logic [2:0] pidx_reg, pidx_next;
    logic [hbrp_pkg::VAL_W-1:0] first_reg, first_next, second_reg, second_next;
    logic sat_reg, sat_next;
    logic [CW-1:0] tcount_reg, tcount_next;
    logic [4:0] acount_reg, acount_next;
    logic [1:0] err_reg, err_next;
    logic cmd_valid_next;
    hbrp_pkg::cmd_t cmd_next;

    logic [7:0] c;
    logic [3:0] d;
    logic is_blank, is_delim, dig;
    logic [hbrp_pkg::VAL_W-1:0] acc_src, acc_val;
    logic acc_ovf, acc_use;
    logic [hbrp_pkg::VAL_W+3:0] prod;

    assign c        = in_item.byte_req;
    assign d        = c[3:0] - 4'd0;
    assign dig      = hbrp_pkg::is_digit(c);
    assign is_blank = (c == 8'h20) || (c == 8'h09);
    assign is_delim = (c == 8'h2C) || (c == 8'h3B);
    assign acc_src  = (tok_reg == TK_FIRST || tok_reg == TK_SUFFIX) ? first_reg :
                      (tok_reg == TK_SECOND) ? second_reg : '0;
    assign prod     = {4'd0, acc_src} * 66'd10 + {62'd0, d};
    assign acc_ovf  = |prod[hbrp_pkg::VAL_W+3:hbrp_pkg::VAL_W];
    assign acc_val  = acc_ovf ? hbrp_pkg::VAL_MAX : prod[hbrp_pkg::VAL_W-1:0];

    always_comb
    begin
        logic fin;
        logic emit;
        logic [4:0] acc_after;
        phase_next = phase_reg;
        tok_next = tok_reg;
        pidx_next = pidx_reg;
        first_next = first_reg;
        second_next = second_reg;
        sat_next = sat_reg;
        tcount_next = tcount_reg;
        acount_next = acount_reg;
        err_next = err_reg;
        cmd_next = '0;
        cmd_valid_next = 1'b0;
        acc_use = 1'b0;
        fin = 1'b0;
        emit = 1'b0;
        acc_after = acount_reg;
        if (in_valid)
        begin
            unique case (phase_reg)
                PH_PREFIX:
                begin
                    if ((c | 8'h20) == hbrp_pkg::unit_char(pidx_reg))
                    begin
                        pidx_next = pidx_reg + 3'd1;
                        if (pidx_reg == 3'd4) phase_next = PH_BEFORE_EQ;
                    end
                    else
                    begin
                        err_next = hbrp_pkg::ST_BADUNIT;
                        phase_next = PH_FAILED;
                    end
                end
                PH_BEFORE_EQ:
                begin
                    if (c == 8'h3D) phase_next = PH_AFTER_EQ;
                    else if (!is_blank)
                    begin
                        err_next = hbrp_pkg::ST_NOEQ;
                        phase_next = PH_FAILED;
                    end
                end
                PH_AFTER_EQ, PH_TOKENS, PH_SKIP:
                begin
                    if (phase_reg == PH_AFTER_EQ && is_blank)
                    begin
                    end
                    else if (is_delim)
                    begin
                        phase_next = PH_TOKENS;
                        fin = (phase_reg != PH_AFTER_EQ);
                    end
                    else if (phase_reg != PH_SKIP)
                    begin
                        phase_next = PH_TOKENS;
                        unique case (tok_reg)
                            TK_START:
                            begin
                                if (tcount_reg >= CW'(MAX_RANGES))
                                begin
                                    tok_next = TK_BAD;
                                    phase_next = PH_SKIP;
                                end
                                else
                                begin
                                    tcount_next = tcount_reg + 1'b1;
                                    if (dig)
                                    begin
                                        tok_next = TK_FIRST;
                                        acc_use = 1'b1;
                                        first_next = acc_val;
                                    end
                                    else if (c == 8'h2D) tok_next = TK_SUF_DASH;
                                    else
                                    begin
                                        tok_next = TK_BAD;
                                        phase_next = PH_SKIP;
                                    end
                                end
                            end
                            TK_FIRST, TK_SUFFIX:
                            begin
                                if (dig)
                                begin
                                    acc_use = 1'b1;
                                    first_next = acc_val;
                                end
                                else if (tok_reg == TK_FIRST && c == 8'h2D) tok_next = TK_DASH;
                                else
                                begin
                                    if (tok_reg == TK_FIRST) tok_next = TK_OPEN;
                                    phase_next = PH_SKIP;
                                end
                            end
                            TK_DASH, TK_SUF_DASH:
                            begin
                                if (dig)
                                begin
                                    acc_use = 1'b1;
                                    if (tok_reg == TK_DASH)
                                    begin
                                        tok_next = TK_SECOND;
                                        second_next = acc_val;
                                    end
                                    else
                                    begin
                                        tok_next = TK_SUFFIX;
                                        first_next = acc_val;
                                    end
                                end
                                else
                                begin
                                    tok_next = (tok_reg == TK_DASH) ? TK_OPEN : TK_BAD;
                                    phase_next = PH_SKIP;
                                end
                            end
                            TK_SECOND:
                            begin
                                if (dig)
                                begin
                                    acc_use = 1'b1;
                                    second_next = acc_val;
                                end
                                else phase_next = PH_SKIP;
                            end
                            default: phase_next = PH_SKIP;
                        endcase
                        if (acc_use && acc_ovf) sat_next = 1'b1;
                    end
                end
                default: ;
            endcase

            if (in_item.last && (phase_next == PH_TOKENS || phase_next == PH_SKIP))
                fin = 1'b1;

            if (fin)
            begin
                // fold this byte's update into the ending token
                cmd_next.first_value  = first_next;
                cmd_next.second_value = second_next;
                cmd_next.sat          = sat_next;
                unique case (tok_next)
                    TK_FIRST, TK_DASH, TK_OPEN:
                    begin
                        emit = 1'b1;
                        cmd_next.kind = hbrp_pkg::KIND_OPEN;
                    end
                    TK_SECOND:
                    begin
                        emit = 1'b1;
                        cmd_next.kind = hbrp_pkg::KIND_CLOSED;
                    end
                    TK_SUFFIX:
                    begin
                        emit = 1'b1;
                        cmd_next.kind = hbrp_pkg::KIND_SUFFIX;
                    end
                    default: ;
                endcase
                cmd_next.has_range = emit;
                if (emit) acc_after = (acount_reg == 5'd31) ? acount_reg : acount_reg + 5'd1;
                acount_next = acc_after;
                tok_next = TK_START;
                first_next = '0;
                second_next = '0;
                sat_next = 1'b0;
                cmd_valid_next = emit;
            end

            if (in_item.last)
            begin
                cmd_valid_next = 1'b1;
                cmd_next.has_status = 1'b1;
                cmd_next.status = err_next;
                cmd_next.count = '0;
                unique case (phase_next)
                    PH_PREFIX: cmd_next.status = hbrp_pkg::ST_BADUNIT;
                    PH_BEFORE_EQ: cmd_next.status = hbrp_pkg::ST_NOEQ;
                    PH_AFTER_EQ: cmd_next.status = hbrp_pkg::ST_EMPTY;
                    PH_TOKENS, PH_SKIP:
                    begin
                        if (tcount_next == '0) cmd_next.status = hbrp_pkg::ST_BADUNIT;
                        else cmd_next.count = acc_after;
                    end
                    default: ;
                endcase
                phase_next = PH_PREFIX;
                tok_next = TK_START;
                pidx_next = '0;
                first_next = '0;
                second_next = '0;
                sat_next = 1'b0;
                tcount_next = '0;
                acount_next = '0;
                err_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            tok_reg <= TK_START;
            pidx_reg <= '0;
            first_reg <= '0;
            second_reg <= '0;
            sat_reg <= 1'b0;
            tcount_reg <= '0;
            acount_reg <= '0;
            err_reg <= '0;
            cmd_valid <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            tok_reg <= tok_next;
            pidx_reg <= pidx_next;
            first_reg <= first_next;
            second_reg <= second_next;
            sat_reg <= sat_next;
            tcount_reg <= tcount_next;
            acount_reg <= acount_next;
            err_reg <= err_next;
            cmd_valid <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd <= cmd_next;
    end
endmodule

[hw/rtl/hbrp_fifo.sv]
// Small command queue between front and back parts.
// Depends on hbrp_pkg for the command type.
module hbrp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  hbrp_pkg::cmd_t wdata,
    input  logic           rd,
    output hbrp_pkg::cmd_t rdata,
    output logic           nonempty,
    output logic           space2
);
    localparam int AW = $clog2(DEPTH);
    hbrp_pkg::cmd_t mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;

    assign rdata    = mem[rp_reg];
    assign nonempty = (cnt_reg != '0);
    assign space2   = (cnt_reg <= (AW+1)'(DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (wr) mem[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule

[hw/rtl/hbrp_back.sv]
// Back part: expands commands into range and status results, one per beat.
// Depends on hbrp_pkg; computes the span subtraction in its output stage.
module hbrp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_avail,
    input  hbrp_pkg::cmd_t      cmd,
    output logic                cmd_take,
    output logic                empty,
    input  logic                pop,
    output hbrp_pkg::out_item_t res
);
    logic half_reg;
    logic valid_reg;
    logic load, emit_range, last_part;
    hbrp_pkg::out_item_t nx;

    // a command with both parts is emitted range first, then status
    assign emit_range = cmd.has_range && !half_reg;
    assign last_part  = !(cmd.has_range && cmd.has_status) || half_reg;
    assign load       = cmd_avail && (!valid_reg || pop);
    assign cmd_take   = load && last_part;
    assign empty      = !valid_reg;

    always_comb
    begin
        nx = '0;
        if (emit_range)
        begin
            nx.kind = cmd.kind;
            nx.saturated = cmd.sat;
            unique case (cmd.kind)
                hbrp_pkg::KIND_CLOSED:
                begin
                    nx.start_pos = cmd.first_value;
                    nx.end_pos = cmd.second_value;
                    nx.span = {2'b00, cmd.second_value} + 64'sd1 - {2'b00, cmd.first_value};
                end
                hbrp_pkg::KIND_SUFFIX: nx.span = {2'b00, cmd.first_value};
                default: nx.start_pos = cmd.first_value;
            endcase
        end
        else
        begin
            nx.is_status = 1'b1;
            nx.status = cmd.status;
            nx.range_count = cmd.count;
            nx.done_res = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg <= 1'b0;
        end
        else
        begin
            if (load) valid_reg <= 1'b1;
            else if (pop) valid_reg <= 1'b0;
            if (load) half_reg <= !last_part;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) res <= nx;
    end
endmodule

[hw/rtl/hbrp_checker.sv]
// Port-level checker for the parser top level, attached by bind.
// Depends on hbrp_pkg for the result type.
module hbrp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input hbrp_pkg::out_item_t out_item
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item))) else $error("result dropped");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_item.is_status == out_item.done_res)) else $error("done mismatch");
    a_rng: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_item.is_status) |-> (out_item.status == hbrp_pkg::ST_OK &&
        out_item.range_count == 5'd0)) else $error("range beat carries status");
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.kind == hbrp_pkg::KIND_SUFFIX) |-> out_item.start_pos == '0)
        else $error("suffix with start");
endmodule

bind http_byte_range_parser_core hbrp_checker u_chk (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .out_item(out_item)
);
